// ===== sv/vehicle_record_headway_queue_top_assert.svh =====
// Assertion macros for the vehicle record headway queue block.
`ifndef VEHICLE_RECORD_HEADWAY_QUEUE_TOP_ASSERT_SVH
`define VEHICLE_RECORD_HEADWAY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Immediate relation checked at every edge.
`define VRHQ_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent at one edge, consequent at the next.
`define VRHQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VRHQ_ASSERT_NOW(lbl, cond, msg)
`define VRHQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/vrhq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrhq_pkg
// Types and constants of the vehicle record headway queue block.
// ----------------------------------------------------------------------------
package vrhq_pkg;

    localparam int LANE_SLOTS_DEF = 49;
    localparam int DVD_W          = 37;   // positive numerator width
    localparam int PROD_W         = 38;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_MUL,
        ST_NUM,
        ST_DIV,
        ST_UPD,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [23:0] last_time;
        logic [7:0]  last_len;
        logic [7:0]  last_spd;
        logic [2:0]  q_cnt;
        logic [23:0] q_start;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{last_time: 24'd0, last_len: 8'd0, last_spd: 8'd0,
                                       q_cnt: 3'd1, q_start: 24'd0};

    function automatic logic signed [8:0] byte_val(input logic [7:0] b);
        byte_val = $signed({1'b0, b}) - 9'sd48;
    endfunction

    function automatic logic signed [27:0] sext28(input logic signed [8:0] v);
        sext28 = {{19{v[8]}}, v};
    endfunction

endpackage
`default_nettype wire

// ===== sv/vehicle_record_headway_queue_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_record_headway_queue_top
// Decodes vehicle detector records and tracks per-slot headway and queues.
// ----------------------------------------------------------------------------
// Usage: present a record on the input channel (in_valid/in_ready, one beat
// per record). The block takes one record at a time; a 37-step restoring
// divider forms the headway. in_ready is high only while no record is in
// work. A result beat appears on out_valid/out_ready only when the record's
// day equals report_day; other records update state silently. The output
// register holds a result while the receiver stalls, and the next record
// may be taken in the meantime; its result waits until the register is
// free. Slot state lives in one synchronous memory, read into a register
// when the slot is known; per-slot valid bits, cleared at reset, make
// unwritten slots read as their reset value, so no clearing pass is
// needed. report_day resets to 1 and is written with report_day_we at
// any edge.
// ----------------------------------------------------------------------------
module vehicle_record_headway_queue_top #(
    parameter int LANE_SLOTS = vrhq_pkg::LANE_SLOTS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               report_day_we,
    input  wire logic [8:0]         report_day_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         year_byte,
    input  wire logic [7:0]         day_high_byte,
    input  wire logic [7:0]         day_low_byte,
    input  wire logic [7:0]         hour_byte,
    input  wire logic [7:0]         minute_byte,
    input  wire logic [7:0]         second_byte,
    input  wire logic [7:0]         hundredth_byte,
    input  wire logic [7:0]         length_byte,
    input  wire logic [7:0]         lane_group_byte,
    input  wire logic [7:0]         speed_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [8:0]       year_value,
    output logic signed [8:0]       length_fifths,
    output logic signed [4:0]       lane_number,
    output logic [1:0]              direction,
    output logic signed [3:0]       lane_class,
    output logic signed [8:0]       speed_value,
    output logic                    faulty_flag,
    output logic signed [27:0]      time_cs,
    output logic signed [27:0]      headway_cs,
    output logic [23:0]             queue_start_cs
);
    import vrhq_pkg::*;

    localparam int IW = (LANE_SLOTS > 1) ? $clog2(LANE_SLOTS) : 1;
    localparam int CW = $clog2(DVD_W);

    state_t state_reg, state_next;

    logic [8:0]  report_day_reg;
    logic [7:0]  yb_reg, dh_reg, dl_reg, hb_reg, mb_reg, sb_reg, cb_reg;
    logic [7:0]  lb_reg, gb_reg, pb_reg;

    entry_t mem [LANE_SLOTS];
    logic [LANE_SLOTS-1:0] vld_reg;
    entry_t ent_reg;
    logic   ent_vld_reg;
    entry_t ent;

    logic [IW-1:0]         slot_reg;
    logic signed [27:0]    held_time_reg;
    logic [23:0]           held_qs_reg;
    logic                  faulty_reg, match_reg, prev_reg, num_pos_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [DVD_W-1:0]      quo_reg;
    logic [7:0]            rem_reg, div_reg;
    logic [CW-1:0]         cnt_reg;
    logic signed [27:0]    hw_reg;

    logic                  out_valid_reg;
    logic signed [8:0]     o_year_reg, o_len_reg, o_spd_reg;
    logic signed [4:0]     o_lane_reg;
    logic [1:0]            o_dir_reg;
    logic signed [3:0]     o_cls_reg;
    logic                  o_faulty_reg;
    logic signed [27:0]    o_time_reg, o_hw_reg;
    logic [23:0]           o_qs_reg;
    logic signed [8:0]     out_year_reg, out_len_reg, out_spd_reg;
    logic signed [4:0]     out_lane_reg;
    logic [1:0]            out_dir_reg;
    logic signed [3:0]     out_cls_reg;

    // ---------------- decode of the held record ----------------
    logic signed [8:0] v_year, v_hr, v_mn, v_sc, v_hs, v_len, v_code, v_spd, v_dh, v_dl;
    logic [8:0]        code_mag;
    logic [3:0]        code_q, code_r;
    logic              code_neg;
    logic signed [4:0] d_lane;
    logic [1:0]        d_dir;
    logic signed [3:0] d_cls;
    logic signed [7:0] slot_s;
    logic [IW-1:0]     slot_idx;
    logic signed [16:0] d_day;
    logic signed [27:0] t_new;
    logic              d_faulty;

    always_comb
    begin
        v_year   = byte_val(yb_reg);
        v_dh     = byte_val(dh_reg);
        v_dl     = byte_val(dl_reg);
        v_hr     = byte_val(hb_reg);
        v_mn     = byte_val(mb_reg);
        v_sc     = byte_val(sb_reg);
        v_hs     = byte_val(cb_reg);
        v_len    = byte_val(lb_reg);
        v_code   = byte_val(gb_reg);
        v_spd    = byte_val(pb_reg);
        code_neg = v_code[8];
        code_mag = code_neg ? 9'(-v_code) : 9'(v_code);
        code_q   = code_mag[7:4];
        code_r   = code_mag[3:0];
        d_lane   = code_neg ? -$signed({1'b0, code_q}) : $signed({1'b0, code_q});
        d_dir    = code_r[3] ? (code_neg ? 2'd0 : 2'd2) : 2'd1;
        d_cls    = code_neg ? -$signed({1'b0, code_r[2:0]}) : $signed({1'b0, code_r[2:0]});
        slot_s   = 8'({{3{d_lane[4]}}, d_lane})
                 + ((d_dir == 2'd0) ? -8'sd25 : (d_dir == 2'd2) ? 8'sd25 : 8'sd0);
        slot_idx = (slot_s >= 8'sd0 && slot_s < $signed(8'(LANE_SLOTS)))
                 ? slot_s[IW-1:0] : '0;
        d_day    = 17'($signed({{8{v_dh[8]}}, v_dh}) * 17'sd200)
                 + $signed({{8{v_dl[8]}}, v_dl});
        t_new    = sext28(v_hr) * 28'sd360000 + sext28(v_mn) * 28'sd6000
                 + sext28(v_sc) * 28'sd100 + sext28(v_hs);
        d_faulty = v_mn < 9'sd0 || v_mn > 9'sd59 || v_code <= 9'sd0 || v_spd < 9'sd2
                || v_spd >= 9'sd199 || v_sc < 9'sd0 || v_sc > 9'sd59 || v_hs < 9'sd0
                || v_hs > 9'sd99 || (d_dir != 2'd1 && d_dir != 2'd2) || d_cls < 4'sd1
                || d_lane <= 5'sd0 || v_hr < 9'sd0 || v_hr > 9'sd23 || d_day < 17'sd1
                || d_day > 17'sd366 || v_year < 9'sd0 || v_year > 9'sd99
                || v_len <= 9'sd5;
    end

    assign ent = ent_vld_reg ? ent_reg : ENTRY_RESET;

    // ---------------- arithmetic on the slot entry ----------------
    logic signed [28:0]       d_diff;
    logic signed [PROD_W-1:0] num;
    logic [8:0]               div_sh;
    logic                     div_ge;

    always_comb
    begin
        d_diff = {held_time_reg[27], held_time_reg} - $signed({5'd0, ent.last_time});
        num    = prod_reg - $signed(PROD_W'({ent.last_len, 6'd0} + {3'd0, ent.last_len, 3'd0}));
        div_sh = {rem_reg, quo_reg[DVD_W-1]};
        div_ge = div_sh >= {1'b0, div_reg};
    end

    // ---------------- queue update ----------------
    logic             in_run;
    logic [2:0]       q_cnt_new;
    logic [23:0]      q_start_new;
    logic [23:0]      held_qs_new;
    logic signed [27:0] hw_new;
    entry_t           ent_new;

    always_comb
    begin
        hw_new = !prev_reg ? -28'sd2 : (!num_pos_reg ? -28'sd1 : $signed(quo_reg[27:0]));
        in_run = prev_reg && (!num_pos_reg || quo_reg < DVD_W'(200));
        q_start_new = ent.q_start;
        held_qs_new = held_qs_reg;
        if (in_run)
        begin
            q_cnt_new = (ent.q_cnt < 3'd7) ? ent.q_cnt + 3'd1 : 3'd7;
            if (q_cnt_new == 3'd2)
                q_start_new = ent.last_time;
            else if (q_cnt_new >= 3'd5)
                held_qs_new = ent.q_start;
        end
        else
        begin
            q_cnt_new   = 3'd1;
            held_qs_new = 24'd0;
        end
        ent_new.last_time = faulty_reg ? ent.last_time : held_time_reg[23:0];
        ent_new.last_len  = faulty_reg ? ent.last_len  : o_len_reg[7:0];
        ent_new.last_spd  = faulty_reg ? ent.last_spd  : o_spd_reg[7:0];
        ent_new.q_cnt     = q_cnt_new;
        ent_new.q_start   = q_start_new;
    end

    // ---------------- control ----------------
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DEC;
            ST_DEC:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_UPD;
            ST_UPD:  state_next = ST_PUSH;
            ST_PUSH: if (!match_reg || out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            report_day_reg <= 9'd1;
            vld_reg        <= '0;
            held_time_reg  <= '0;
            held_qs_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (report_day_we)
                report_day_reg <= report_day_wdata;
            if (state_reg == ST_DEC && d_lane > 5'sd0 && d_dir != 2'd0)
                held_time_reg <= t_new;
            if (state_reg == ST_UPD)
            begin
                vld_reg[slot_reg] <= 1'b1;
                held_qs_reg       <= held_qs_new;
            end
            // hold the beat until taken, load a new one on push
            out_valid_reg <= (out_valid_reg && !out_ready)
                          || (state_reg == ST_PUSH && match_reg && out_free);
        end
    end

    // slot memory: read in the decode cycle, write back after the divide
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DEC)
        begin
            ent_reg     <= mem[slot_idx];
            ent_vld_reg <= vld_reg[slot_idx];
        end
        if (state_reg == ST_UPD)
            mem[slot_reg] <= ent_new;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            yb_reg <= year_byte;      dh_reg <= day_high_byte;  dl_reg <= day_low_byte;
            hb_reg <= hour_byte;      mb_reg <= minute_byte;    sb_reg <= second_byte;
            cb_reg <= hundredth_byte; lb_reg <= length_byte;    gb_reg <= lane_group_byte;
            pb_reg <= speed_byte;
        end
        case (state_reg)
            ST_DEC:
            begin
                slot_reg   <= slot_idx;
                faulty_reg <= d_faulty;
                match_reg  <= d_day == $signed({8'd0, report_day_reg});
                o_year_reg <= v_year;
                o_len_reg  <= v_len;
                o_spd_reg  <= v_spd;
                o_lane_reg <= d_lane;
                o_dir_reg  <= d_dir;
                o_cls_reg  <= d_cls;
            end
            ST_MUL:
            begin
                prev_reg <= ent.last_time != 24'd0 && ent.last_len != 8'd0
                         && ent.last_spd != 8'd0;
                prod_reg <= PROD_W'(d_diff * $signed({1'b0, ent.last_spd}));
            end
            ST_NUM:
            begin
                num_pos_reg <= !num[PROD_W-1] && (num != '0);
                quo_reg     <= num[DVD_W-1:0];
                rem_reg     <= 8'd0;
                div_reg     <= ent.last_spd;
                cnt_reg     <= CW'(DVD_W - 1);
            end
            ST_DIV:
            begin
                // shift one dividend bit into the remainder, subtract if it fits
                rem_reg <= div_ge ? 8'(div_sh - {1'b0, div_reg}) : div_sh[7:0];
                quo_reg <= {quo_reg[DVD_W-2:0], div_ge};
                cnt_reg <= cnt_reg - CW'(1);
            end
            ST_UPD:
                hw_reg <= hw_new;
            default:
            begin
            end
        endcase
        if (state_reg == ST_PUSH && match_reg && out_free)
        begin
            o_faulty_reg <= faulty_reg;
            o_time_reg   <= held_time_reg;
            o_hw_reg     <= hw_reg;
            o_qs_reg     <= held_qs_reg;
            out_year_reg <= o_year_reg;
            out_len_reg  <= o_len_reg;
            out_spd_reg  <= o_spd_reg;
            out_lane_reg <= o_lane_reg;
            out_dir_reg  <= o_dir_reg;
            out_cls_reg  <= o_cls_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign year_value     = out_year_reg;
    assign length_fifths  = out_len_reg;
    assign speed_value    = out_spd_reg;
    assign lane_number    = out_lane_reg;
    assign direction      = out_dir_reg;
    assign lane_class     = out_cls_reg;
    assign faulty_flag    = o_faulty_reg;
    assign time_cs        = o_time_reg;
    assign headway_cs     = o_hw_reg;
    assign queue_start_cs = o_qs_reg;

`include "vehicle_record_headway_queue_top_assert.svh"

    `VRHQ_ASSERT_NOW(a_rem_below_div, state_reg != ST_DIV || rem_reg < div_reg || div_reg == 8'd0, "divider remainder not below divisor")
    `VRHQ_ASSERT_NEXT(a_div_done, state_reg == ST_DIV && cnt_reg == '0, state_reg == ST_UPD, "divider did not finish")
    `VRHQ_ASSERT_NEXT(a_out_from_push, !out_valid_reg && !(state_reg == ST_PUSH && match_reg), !out_valid_reg, "result beat without push")

endmodule
`default_nettype wire
